// ===== rtl/core/kmsd_pkg.sv =====
// shared types, constants and helpers for the key matrix scan debouncer
// no dependencies; imported by kmsd_matrix, key_matrix_scan_debouncer, kmsd_checker and the testbench
package kmsd_pkg;

    localparam int ROW_W     = 3;
    localparam int PIN_W     = 16;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SCANS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PINS_ACTIVE_HIGH = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [PIN_W-1:0] column_pins;
        logic             end_of_scan;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_scans;
        logic             pins_active_high;
    } t_cfg;

    typedef struct packed {
        logic [PIN_W-1:0] stable_row;
        logic             row_changed;
        logic             settled;
        logic             committed;
        logic [CNT_W-1:0] pressed_count;
    } t_result;

    function automatic logic [4:0] popcount16(input logic [PIN_W-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < PIN_W; i++) begin
            n = n + 5'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/key_matrix_scan_debouncer.sv =====
// top level of the key matrix scan debouncer: input register, result register,
// configuration registers; depends on kmsd_pkg and kmsd_matrix
//
// usage:
//   input channel  i_valid / o_stall carries one row sample per item
//   (row index, raw column pins, end-of-scan mark); taken when i_valid && !o_stall
//   output channel o_valid / i_stall carries one result per item
//   (stable row, row changed, settled, committed, pressed key count)
//   config port    i_cfg_we / i_cfg_idx / i_cfg_data, written while i_cfg_we is high:
//   index 0 debounce reload in full scans (0 acts as 1), index 1 pin polarity
// path: an accepted item waits in the input register, then steps into the result register
// throughput: one item per clock while the receiver does not stall; the row update,
//   countdown step and commit are combinational between the input and result registers
// reset (synchronous, active low): all rows cleared, countdown and reload 5,
//   polarity active low, both channels empty
// stalls: a held result keeps the next item in the input register; o_stall
//   rises only when both registers are full and the receiver stalls
module key_matrix_scan_debouncer #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [kmsd_pkg::ROW_W-1:0]        i_row_index,
    input  logic [kmsd_pkg::PIN_W-1:0]        i_column_pins,
    input  logic                              i_end_of_scan,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [kmsd_pkg::PIN_W-1:0]        o_stable_row,
    output logic                              o_row_changed,
    output logic                              o_settled,
    output logic                              o_committed,
    output logic [kmsd_pkg::CNT_W-1:0]        o_pressed_count,
    input  logic                              i_cfg_we,
    input  logic [kmsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kmsd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import kmsd_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_cfg    r_cfg;
    t_result step_res;
    logic    advance;
    logic    in_accept;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    kmsd_matrix #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_item.row_index   <= i_row_index;
            r_item.column_pins <= i_column_pins;
            r_item.end_of_scan <= i_end_of_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_scans   <= DEBOUNCE_RESET;
            r_cfg.pins_active_high <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE_SCANS:   r_cfg.debounce_scans   <= i_cfg_data;
                CFG_PINS_ACTIVE_HIGH: r_cfg.pins_active_high <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_stable_row    = r_res.stable_row;
    assign o_row_changed   = r_res.row_changed;
    assign o_settled       = r_res.settled;
    assign o_committed     = r_res.committed;
    assign o_pressed_count = r_res.pressed_count;

`ifndef SYNTHESIS
    a_commit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_res.committed || r_res.settled))
        else $error("commit reported while not settled");

    a_item_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall) |=> (r_in_valid && $stable(r_item)))
        else $error("pending item lost while output stalled");

    a_result_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("stepped item produced no result");
`endif

endmodule

// ===== rtl/core/kmsd_matrix.sv =====
// pending and stable row storage, shared countdown and key counts
// depends on kmsd_pkg; one step per item, result is combinational
module kmsd_matrix #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  kmsd_pkg::t_item   i_item,
    input  kmsd_pkg::t_cfg    i_cfg,
    output kmsd_pkg::t_result o_res
);
    import kmsd_pkg::*;

    localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW  = $clog2(ROWS * COLS + 1);
    localparam int SW  = TW + 6;

    logic [COLS-1:0]  r_pending [ROWS];
    logic [COLS-1:0]  r_stable  [ROWS];
    logic [CNT_W-1:0] r_countdown;
    logic [TW-1:0]    r_pending_total;
    logic [TW-1:0]    r_stable_total;

    logic [PIN_W-1:0] pins_pressed;
    logic [COLS-1:0]  sample;
    logic             in_range;
    logic [RIW-1:0]   idx;
    logic [COLS-1:0]  old_row;
    logic             changed;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] cnt_mid;
    logic [CNT_W-1:0] n_countdown;
    logic             commit;
    logic [TW-1:0]    n_pending_total;
    logic [TW-1:0]    n_stable_total;
    logic [COLS-1:0]  srow;

    always_comb begin
        pins_pressed = i_cfg.pins_active_high ? i_item.column_pins : ~i_item.column_pins;
        sample       = pins_pressed[COLS-1:0];
        in_range     = (32'(i_item.row_index) < ROWS);
        idx          = in_range ? RIW'(i_item.row_index) : '0;
        old_row      = r_pending[idx];
        changed      = in_range && (old_row != sample);
        reload       = (i_cfg.debounce_scans == '0) ? CNT_W'(1) : i_cfg.debounce_scans;
        cnt_mid      = changed ? reload : r_countdown;

        n_pending_total = r_pending_total;
        if (changed) begin
            n_pending_total = TW'(SW'(r_pending_total) - SW'(popcount16(PIN_W'(old_row)))
                                  + SW'(popcount16(PIN_W'(sample))));
        end

        n_countdown = cnt_mid;
        commit      = 1'b0;
        if (i_item.end_of_scan && (cnt_mid != '0)) begin
            n_countdown = cnt_mid - CNT_W'(1);
            commit      = (n_countdown == '0);
        end

        n_stable_total = commit ? n_pending_total : r_stable_total;

        // after a commit this row's stable copy equals the fresh sample
        if (!in_range) begin
            srow = '0;
        end else if (commit) begin
            srow = sample;
        end else begin
            srow = r_stable[idx];
        end

        o_res.stable_row    = PIN_W'(srow);
        o_res.row_changed   = changed;
        o_res.settled       = (n_countdown == '0);
        o_res.committed     = commit;
        o_res.pressed_count = (32'(n_stable_total) > 255) ? 8'hFF : CNT_W'(n_stable_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_pending[r] <= '0;
                r_stable[r]  <= '0;
            end
            r_countdown     <= DEBOUNCE_RESET;
            r_pending_total <= '0;
            r_stable_total  <= '0;
        end else if (i_step) begin
            if (changed) begin
                r_pending[idx] <= sample;
            end
            if (commit) begin
                // the sampled row takes its fresh sample, every other row its pending copy
                for (int r = 0; r < ROWS; r++) begin
                    if (in_range && (RIW'(r) == idx)) begin
                        r_stable[r] <= sample;
                    end else begin
                        r_stable[r] <= r_pending[r];
                    end
                end
            end
            r_countdown     <= n_countdown;
            r_pending_total <= n_pending_total;
            r_stable_total  <= n_stable_total;
        end
    end

`ifndef SYNTHESIS
    a_countdown_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_countdown))
        else $error("countdown moved without an item");

    a_stable_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !commit) |=> $stable(r_stable_total))
        else $error("stable count moved without a commit");

    a_commit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && commit) |=> (r_countdown == '0 && r_stable_total == r_pending_total))
        else $error("commit left countdown or counts inconsistent");
`endif

endmodule

// ===== verif/kmsd_checker.sv =====
`timescale 1ns / 1ps
// result checker for the key matrix scan debouncer: tracks register writes and
// accepted items, predicts every result and compares it; depends on kmsd_pkg
module kmsd_checker #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [kmsd_pkg::ROW_W-1:0]     i_row_index,
    input  logic [kmsd_pkg::PIN_W-1:0]     i_column_pins,
    input  logic                           i_end_of_scan,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [kmsd_pkg::PIN_W-1:0]     i_stable_row,
    input  logic                           i_row_changed,
    input  logic                           i_settled,
    input  logic                           i_committed,
    input  logic [kmsd_pkg::CNT_W-1:0]     i_pressed_count,
    input  logic                           i_cfg_we,
    input  logic [kmsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kmsd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    import kmsd_pkg::*;

    localparam logic [PIN_W-1:0] COL_MASK = PIN_W'((64'd1 << COLS) - 64'd1);

    logic [PIN_W-1:0] pending_rows [ROWS];
    logic [PIN_W-1:0] stable_rows [ROWS];
    logic [CNT_W-1:0] countdown;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] pending_keys;
    logic [CNT_W-1:0] stable_keys;
    logic             active_high;
    t_result          scan_results_q [$];

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
    end

    function automatic logic [CNT_W-1:0] keys_down();
        int total;
        total = 0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < PIN_W; c++) begin
                total += int'(pending_rows[r][c]);
            end
        end
        return (total > 255) ? 8'd255 : CNT_W'(total);
    endfunction

    // one item: compare and store the row first, then the end-of-scan countdown step
    function automatic t_result debounce_step(input logic [ROW_W-1:0] row,
                                              input logic [PIN_W-1:0] pins,
                                              input logic eos);
        t_result          res;
        logic [PIN_W-1:0] pressed;
        res = '0;
        pressed = (active_high ? pins : ~pins) & COL_MASK;
        if (int'(row) < ROWS && pending_rows[row] != pressed) begin
            pending_rows[row] = pressed;
            pending_keys = keys_down();
            countdown = (reload == 0) ? 8'd1 : reload;
            res.row_changed = 1'b1;
        end
        if (eos && countdown != 0) begin
            countdown = countdown - 1'b1;
            if (countdown == 0) begin
                for (int r = 0; r < ROWS; r++) begin
                    stable_rows[r] = pending_rows[r];
                end
                stable_keys = pending_keys;
                res.committed = 1'b1;
            end
        end
        if (int'(row) < ROWS) begin
            res.stable_row = stable_rows[row];
        end
        res.settled = (countdown == 0);
        res.pressed_count = stable_keys;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [PIN_W-1:0] want,
                                 input logic [PIN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                pending_rows[r] = '0;
                stable_rows[r] = '0;
            end
            countdown = DEBOUNCE_RESET;
            reload = DEBOUNCE_RESET;
            active_high = 1'b0;
            pending_keys = '0;
            stable_keys = '0;
            scan_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (scan_results_q.size() == 0) begin
                    $error("result with no item outstanding: stable_row %0h", i_stable_row);
                    o_fail_count++;
                end else begin
                    want = scan_results_q.pop_front();
                    compare_field("stable_row", want.stable_row, i_stable_row);
                    compare_field("row_changed", want.row_changed, i_row_changed);
                    compare_field("settled", want.settled, i_settled);
                    compare_field("committed", want.committed, i_committed);
                    compare_field("pressed_count", want.pressed_count, i_pressed_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_results_q.push_back(debounce_step(i_row_index, i_column_pins,
                                                       i_end_of_scan));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE_SCANS: begin
                        reload = i_cfg_data;
                    end
                    CFG_PINS_ACTIVE_HIGH: begin
                        active_high = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_outstanding = scan_results_q.size();
    end

endmodule

// ===== verif/tb_key_matrix_scan_debouncer.sv =====
`timescale 1ns / 1ps
// testbench top for the key matrix scan debouncer: clock, reset, register writes,
// directed and random row samples and the verdict; depends on kmsd_pkg and kmsd_checker
module tb_key_matrix_scan_debouncer;
    import kmsd_pkg::*;

    localparam int ROWS         = 8;
    localparam int COLS         = 16;
    localparam int RUN_ITEMS    = 1700;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [ROW_W-1:0]     i_row_index;
    logic [PIN_W-1:0]     i_column_pins;
    logic                 i_end_of_scan;
    logic                 o_valid;
    logic                 i_stall;
    logic [PIN_W-1:0]     o_stable_row;
    logic                 o_row_changed;
    logic                 o_settled;
    logic                 o_committed;
    logic [CNT_W-1:0]     o_pressed_count;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    int               fail_count;
    int               outstanding;
    int               cycle_count;
    int               sent;
    int               send_quiet;
    bit               calm;
    logic             active_high;
    logic [PIN_W-1:0] held_keys [ROWS];

    key_matrix_scan_debouncer #(.ROWS(ROWS), .COLS(COLS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_row_index(i_row_index), .i_column_pins(i_column_pins),
        .i_end_of_scan(i_end_of_scan),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_stable_row(o_stable_row), .o_row_changed(o_row_changed),
        .o_settled(o_settled), .o_committed(o_committed),
        .o_pressed_count(o_pressed_count),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    kmsd_checker #(.ROWS(ROWS), .COLS(COLS)) scan_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_row_index(i_row_index), .i_column_pins(i_column_pins),
        .i_end_of_scan(i_end_of_scan),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_stable_row(o_stable_row), .i_row_changed(o_row_changed),
        .i_settled(o_settled), .i_committed(o_committed),
        .i_pressed_count(o_pressed_count),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_key_matrix_scan_debouncer: FAIL");
        $finish;
    end

    // receiver stalls in bursts of random length, with stall-free stretches
    initial begin : receiver
        int burst;
        int quiet;
        burst = 0;
        quiet = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (quiet > 0 || calm || $urandom_range(0, 5) != 0) begin
                if (quiet > 0) begin
                    quiet--;
                end
                i_stall <= 1'b0;
            end else begin
                burst = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) begin
                    quiet = $urandom_range(20, 80);
                end
                i_stall <= 1'b1;
            end
        end
    end

    task automatic send_scan(input logic [ROW_W-1:0] row, input logic [PIN_W-1:0] pins,
                             input logic eos);
        int gap;
        if (send_quiet > 0) begin
            send_quiet--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            if ($urandom_range(0, 3) == 0) begin
                send_quiet = $urandom_range(16, 64);
            end
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_row_index <= row;
        i_column_pins <= pins;
        i_end_of_scan <= eos;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly full scans of the held keys with some bounce, plus partial scans and noise
    task automatic scan_phase(input int scans);
        logic [PIN_W-1:0] pins;
        int               pick;
        int               bounce_row;
        int               last_row;
        for (int s = 0; s < scans; s++) begin
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, ROWS - 1);
                held_keys[pick] = held_keys[pick] ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1));
            end
            if ($urandom_range(0, 19) == 0) begin
                pick = $urandom_range(0, ROWS - 1);
                held_keys[pick] = PIN_W'($urandom);
            end
            if ($urandom_range(0, 29) == 0) begin
                for (int r = 0; r < ROWS; r++) begin
                    held_keys[r] = '0;
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                wait_idle();
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 4)) begin
                        send_scan(ROW_W'($urandom), PIN_W'($urandom), 1'($urandom));
                    end
                end
                1: begin
                    last_row = $urandom_range(0, ROWS - 2);
                    for (int r = 0; r <= last_row; r++) begin
                        pins = active_high ? held_keys[r] : ~held_keys[r];
                        send_scan(ROW_W'(r), pins, $urandom_range(0, 3) == 0);
                    end
                end
                default: begin
                    bounce_row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROWS - 1) : ROWS;
                    for (int r = 0; r < ROWS; r++) begin
                        pins = held_keys[r];
                        if (r == bounce_row) begin
                            pins = pins ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1));
                        end
                        send_scan(ROW_W'(r), active_high ? pins : ~pins, r == ROWS - 1);
                    end
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int goal;
        int reload;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_row_index = '0;
        i_column_pins = '0;
        i_end_of_scan = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEBOUNCE_SCANS;
        i_cfg_data = '0;
        calm = 1'b0;
        sent = 0;
        send_quiet = 0;
        active_high = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            held_keys[r] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: a sample equal to pending, a full row, countdown running out
        send_scan(3'd0, 16'hFFFF, 1'b0);
        send_scan(3'd7, 16'h0000, 1'b0);
        send_scan(3'd3, 16'h5555, 1'b1);
        repeat (5) send_scan(3'd7, 16'h0000, 1'b1);
        wait_idle();

        // zero reload acts as one, so a change and a commit fall on one item
        write_reg(CFG_DEBOUNCE_SCANS, 8'd0);
        write_reg(CFG_PINS_ACTIVE_HIGH, 8'hFF);
        send_scan(3'd5, 16'hFFFF, 1'b1);
        send_scan(3'd5, 16'hFFFF, 1'b1);
        for (int r = 0; r < ROWS; r++) begin
            send_scan(ROW_W'(r), 16'hFFFF, r == ROWS - 1);
        end
        send_scan(3'd2, 16'h0000, 1'b1);
        wait_idle();

        // longest reload; the countdown keeps running across the next writes
        write_reg(CFG_DEBOUNCE_SCANS, 8'd255);
        write_reg(CFG_PINS_ACTIVE_HIGH, 8'h00);
        send_scan(3'd6, 16'h8001, 1'b1);
        send_scan(3'd6, 16'h8001, 1'b1);

        goal = sent + RUN_ITEMS;
        while (sent < goal) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: reload = 0;
                1: reload = 1;
                2: reload = 255;
                3: reload = $urandom_range(1, 255);
                default: reload = $urandom_range(1, 6);
            endcase
            active_high = 1'($urandom);
            write_reg(CFG_DEBOUNCE_SCANS, CFG_DAT_W'(reload));
            write_reg(CFG_PINS_ACTIVE_HIGH, CFG_DAT_W'({$urandom_range(0, 127), active_high}));
            if (goal - sent <= CALM_ITEMS) begin
                calm = 1'b1;
            end
            scan_phase($urandom_range(10, 30));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_key_matrix_scan_debouncer: PASS");
        end else begin
            $display("tb_key_matrix_scan_debouncer: FAIL");
        end
        $finish;
    end

endmodule

// ===== key_matrix_scan_debouncer.f =====
rtl/core/kmsd_pkg.sv
rtl/core/kmsd_matrix.sv
rtl/core/key_matrix_scan_debouncer.sv
verif/kmsd_checker.sv
verif/tb_key_matrix_scan_debouncer.sv
